>>> hw/rtl/dslc_pkg.sv
// ----------------------------------------------------------------------------
// dslc_pkg
// Shared types, register indexes and reset values of the deadband step
// level controller.
// ----------------------------------------------------------------------------
package dslc_pkg;

  localparam int SETPOINT_W = 24;
  localparam int BAND_W     = 23;
  localparam int LEVEL_W    = 8;
  localparam int ERR_W      = 25;
  localparam int STEP_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef logic signed [SETPOINT_W-1:0] setpoint_t;
  typedef logic        [BAND_W-1:0]     band_t;
  typedef logic signed [LEVEL_W-1:0]    level_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic signed [STEP_W-1:0]     step_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_SETPOINT    = 3'd0;
  localparam cfg_idx_t REG_COARSE_BAND = 3'd1;
  localparam cfg_idx_t REG_FAST_BAND   = 3'd2;
  localparam cfg_idx_t REG_FINE_BAND   = 3'd3;
  localparam cfg_idx_t REG_FLOOR       = 3'd4;
  localparam cfg_idx_t REG_CEILING     = 3'd5;
  localparam cfg_idx_t REG_START_LEVEL = 3'd6;

  // reset values
  localparam setpoint_t SETPOINT_RST    = 24'sd25;
  localparam band_t     COARSE_BAND_RST = 23'd50;
  localparam band_t     FAST_BAND_RST   = 23'd200;
  localparam band_t     FINE_BAND_RST   = 23'd4;
  localparam level_t    FLOOR_RST       = -8'sd110;
  localparam level_t    CEILING_RST     = -8'sd10;
  localparam level_t    START_LEVEL_RST = -8'sd10;

  localparam err_t ERR_MAX = 25'sh0FFFFFF;
  localparam err_t ERR_MIN = 25'sh1000000;

  typedef struct packed {
    setpoint_t setpoint;
    band_t     coarse_band;
    band_t     fast_band;
    band_t     fine_band;
    level_t    level_floor;
    level_t    level_ceiling;
  } cfg_t;

endpackage

>>> hw/rtl/dslc_ifs.sv
// ----------------------------------------------------------------------------
// dslc_ifs
// Valid/ready channels of the deadband step level controller: sample input,
// result output and register write port.
// ----------------------------------------------------------------------------
interface dslc_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface dslc_out_if;
  import dslc_pkg::*;

  logic   valid;
  logic   ready;
  level_t drive_level;
  err_t   error_value;
  step_t  step_applied;

  modport source (output valid, output drive_level, output error_value,
                  output step_applied, input ready);
  modport sink   (input valid, input drive_level, input error_value,
                  input step_applied, output ready);
endinterface

interface dslc_cfg_if;
  import dslc_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/dslc_mean.sv
// ----------------------------------------------------------------------------
// dslc_mean
// Moving mean over the current sample and the previous TAPS-1 samples,
// truncated toward zero. Three stages: sum, reciprocal multiply, scale/sign.
// ----------------------------------------------------------------------------
module dslc_mean #(
  parameter int TAPS        = 5,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                        avg_valid,
  input  logic                        avg_ready,
  output logic signed [SAMPLE_BITS:0] avg
);

  localparam int CLOG_N = $clog2(TAPS);
  localparam int HIST_D = TAPS - 1;
  localparam int SUM_W  = SAMPLE_BITS + CLOG_N;
  localparam int MAG_W  = SUM_W;
  // shift large enough that the rounded-up reciprocal gives the exact floor
  localparam int SH     = MAG_W + CLOG_N;
  localparam int M_W    = MAG_W + 2;
  localparam int LO_W   = MAG_W / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PROD_W = MAG_W + M_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(TAPS) - 64'd1) / 64'(TAPS);
  localparam logic [M_W-1:0] M = RECIP[M_W-1:0];

  logic signed [SAMPLE_BITS-1:0] hist_r [HIST_D];

  logic                    v1_r, v2_r, v3_r;
  logic                    rdy1, rdy2, rdy3;
  logic signed [SUM_W-1:0] sum_nxt, sum_r;
  logic [MAG_W-1:0]        mag;
  logic                    neg2_r;
  logic [LO_W+M_W-1:0]     pl_nxt, pl_r;
  logic [HI_W+M_W-1:0]     ph_nxt, ph_r;
  logic [PROD_W-1:0]       prod;
  logic [SAMPLE_BITS-1:0]  quot;
  logic signed [SAMPLE_BITS:0] avg_nxt, avg_r;

  assign rdy3     = !v3_r || avg_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    sum_nxt = SUM_W'(in_sample);
    for (int i = 0; i < HIST_D; i++) begin
      sum_nxt = sum_nxt + SUM_W'(hist_r[i]);
    end
  end

  // magnitude; the most negative sum maps to its correct unsigned value
  assign mag    = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
  assign pl_nxt = (LO_W+M_W)'(mag[LO_W-1:0]) * (LO_W+M_W)'(M);
  assign ph_nxt = (HI_W+M_W)'(mag[MAG_W-1:LO_W]) * (HI_W+M_W)'(M);

  assign prod    = (PROD_W'(ph_r) << LO_W) + PROD_W'(pl_r);
  assign quot    = prod[SH +: SAMPLE_BITS];
  assign avg_nxt = neg2_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int i = 0; i < HIST_D; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy1 && in_valid) begin
        hist_r[0] <= in_sample;
        for (int i = 1; i < HIST_D; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sum_r <= sum_nxt;
    end
    if (rdy2 && v1_r) begin
      neg2_r <= sum_r[SUM_W-1];
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
    end
    if (rdy3 && v2_r) begin
      avg_r <= avg_nxt;
    end
  end

  assign avg_valid = v3_r;
  assign avg       = avg_r;

endmodule

>>> hw/rtl/dslc_law.sv
// ----------------------------------------------------------------------------
// dslc_law
// Deadband step law: step from the coarse, fast and (periodic) fine bands,
// then the clamped next drive level.
// ----------------------------------------------------------------------------
module dslc_law (
  input  dslc_pkg::cfg_t   cfg,
  input  dslc_pkg::err_t   err,
  input  dslc_pkg::level_t level,
  input  logic             fine_en,
  output dslc_pkg::step_t  step,
  output dslc_pkg::level_t level_nxt
);
  import dslc_pkg::*;

  localparam int CMP_W = ERR_W + 1;
  localparam int LVL_W = LEVEL_W + 2;

  // +1 above +band, -1 below -band, strict on both sides
  function automatic step_t band_step(input err_t e, input band_t b);
    logic signed [CMP_W-1:0] ex;
    logic signed [CMP_W-1:0] bx;
    ex = CMP_W'(e);
    bx = $signed(CMP_W'(b));
    if (ex > bx) begin
      return 3'sd1;
    end else if (ex < -bx) begin
      return -3'sd1;
    end
    return 3'sd0;
  endfunction

  logic signed [LVL_W-1:0] lvl;

  always_comb begin
    step = band_step(err, cfg.coarse_band) + band_step(err, cfg.fast_band);
    if (fine_en) begin
      step = step + band_step(err, cfg.fine_band);
    end
    lvl = LVL_W'(level) + LVL_W'(step);
    // floor first, ceiling last: ceiling wins if the limits cross
    if (lvl < LVL_W'(cfg.level_floor)) begin
      lvl = LVL_W'(cfg.level_floor);
    end
    if (lvl > LVL_W'(cfg.level_ceiling)) begin
      lvl = LVL_W'(cfg.level_ceiling);
    end
    level_nxt = LEVEL_W'(lvl);
  end

endmodule

>>> hw/rtl/deadband_step_level_controller.sv
// ----------------------------------------------------------------------------
// deadband_step_level_controller
// Five-tap mean of ADC samples, error against a setpoint code, deadband
// step law and clamped drive level, one result per sample.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transfer
//  in_ch    in   sample                                    valid & ready
//  out_ch   out  drive_level, error_value, step_applied    valid & ready
//  cfg_ch   in   index, data                               valid & ready
//
//  One sample per cycle while the output is not stalled; a result passes
//  through the sum, reciprocal multiply, scale, error and level stages,
//  the sum stage loaded at the transfer edge.
//  The drive level feeds back only within the last stage.
//  Reset clears the sample history to zero, the fine-step phase to zero and
//  loads the registers and drive level with their defaults.
//  A stalled output backs up the pipeline stage by stage; empty stages keep
//  taking samples. cfg_ch is always ready.
// ----------------------------------------------------------------------------
module deadband_step_level_controller #(
  parameter int AVERAGE_TAPS     = 5,
  parameter int FINE_PERIOD_LOG2 = 7,
  parameter int SAMPLE_BITS      = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  dslc_in_if.sink    in_ch,
  dslc_out_if.source out_ch,
  dslc_cfg_if.sink   cfg_ch
);
  import dslc_pkg::*;

  localparam int AVG_W = SAMPLE_BITS + 1;
  localparam int EW    = ((AVG_W > ERR_W) ? AVG_W : ERR_W) + 1;

  cfg_t   cfg_r;
  level_t level_r;
  logic [FINE_PERIOD_LOG2-1:0] phase_r;

  logic                    avg_valid, avg_ready;
  logic signed [AVG_W-1:0] avg;

  logic                 v4_r, rdy4, out_free, out_ld;
  logic signed [EW-1:0] err_full;
  err_t                 err_sat, err4_r;

  step_t  step;
  level_t level_nxt;

  logic   ov_r;
  level_t out_lvl_r;
  err_t   out_err_r;
  step_t  out_step_r;

  dslc_mean #(
    .TAPS        (AVERAGE_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.sample),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg       (avg)
  );

  assign out_free  = !ov_r || out_ch.ready;
  assign out_ld    = v4_r && out_free;
  assign rdy4      = !v4_r || out_free;
  assign avg_ready = rdy4;

  // error, saturated to the output width
  always_comb begin
    err_full = EW'(avg) - EW'(cfg_r.setpoint);
    if (err_full > EW'(ERR_MAX)) begin
      err_sat = ERR_MAX;
    end else if (err_full < EW'(ERR_MIN)) begin
      err_sat = ERR_MIN;
    end else begin
      err_sat = ERR_W'(err_full);
    end
  end

  dslc_law u_law (
    .cfg       (cfg_r),
    .err       (err4_r),
    .level     (level_r),
    .fine_en   (phase_r == '0),
    .step      (step),
    .level_nxt (level_nxt)
  );

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint      <= SETPOINT_RST;
      cfg_r.coarse_band   <= COARSE_BAND_RST;
      cfg_r.fast_band     <= FAST_BAND_RST;
      cfg_r.fine_band     <= FINE_BAND_RST;
      cfg_r.level_floor   <= FLOOR_RST;
      cfg_r.level_ceiling <= CEILING_RST;
      level_r             <= START_LEVEL_RST;
      phase_r             <= '0;
      v4_r                <= 1'b0;
      ov_r                <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_r <= avg_valid;
      end
      if (out_free) begin
        ov_r <= v4_r;
      end
      if (out_ld) begin
        level_r <= level_nxt;
        phase_r <= phase_r + FINE_PERIOD_LOG2'(1);
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_SETPOINT:    cfg_r.setpoint      <= cfg_ch.data[SETPOINT_W-1:0];
          REG_COARSE_BAND: cfg_r.coarse_band   <= cfg_ch.data[BAND_W-1:0];
          REG_FAST_BAND:   cfg_r.fast_band     <= cfg_ch.data[BAND_W-1:0];
          REG_FINE_BAND:   cfg_r.fine_band     <= cfg_ch.data[BAND_W-1:0];
          REG_FLOOR:       cfg_r.level_floor   <= cfg_ch.data[LEVEL_W-1:0];
          REG_CEILING:     cfg_r.level_ceiling <= cfg_ch.data[LEVEL_W-1:0];
          REG_START_LEVEL: level_r             <= cfg_ch.data[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && avg_valid) begin
      err4_r <= err_sat;
    end
    if (out_ld) begin
      out_lvl_r  <= level_nxt;
      out_err_r  <= err4_r;
      out_step_r <= step;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.drive_level  = out_lvl_r;
  assign out_ch.error_value  = out_err_r;
  assign out_ch.step_applied = out_step_r;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deadband step level controller. Samples stream
// in through a queue-fed driver, a per-transfer predictor computes the mean,
// error, step and clamped level of each transfer, and a monitor compares each
// result against the oldest prediction under varied idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dslc_pkg::*;

  localparam int       TAPS           = 5;
  localparam int       HIST_DEPTH     = TAPS - 1;
  localparam int       RX_HOLD_CYCLES = 300;
  localparam int       STALL_LIMIT    = 4000;
  localparam int       REPORT_LIMIT   = 60;
  localparam int       PHASES         = 9;
  localparam int       RAND_PER_PHASE = 160;
  localparam cfg_idx_t REG_UNUSED     = 3'd7;
  localparam longint   SAMPLE_MAX     = 64'sd8388607;
  localparam longint   SAMPLE_MIN     = -64'sd8388608;

  typedef logic signed [23:0] sample_t;

  typedef struct {
    level_t drive_level;
    err_t   error_value;
    step_t  step_applied;
  } result_t;

  logic clk;
  logic rst_n;

  dslc_in_if #(.SAMPLE_BITS(24)) in_bus();
  dslc_out_if                    out_bus();
  dslc_cfg_if                    cfg_bus();

  deadband_step_level_controller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // predictor copy of registers and state
  setpoint_t            cfg_setpoint;
  band_t                cfg_coarse;
  band_t                cfg_fast;
  band_t                cfg_fine;
  level_t               cfg_floor;
  level_t               cfg_ceiling;
  level_t               cfg_start;
  sample_t              history [HIST_DEPTH];
  logic [6:0]           fine_phase;
  level_t               drive_state;

  sample_t sample_queue [$];
  result_t expected_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int rx_hold_req;
  int rx_hold_seen;
  int rx_hold_count;
  int mismatch_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic reset_model();
    cfg_setpoint = SETPOINT_RST;
    cfg_coarse   = COARSE_BAND_RST;
    cfg_fast     = FAST_BAND_RST;
    cfg_fine     = FINE_BAND_RST;
    cfg_floor    = FLOOR_RST;
    cfg_ceiling  = CEILING_RST;
    cfg_start    = START_LEVEL_RST;
    for (int i = 0; i < HIST_DEPTH; i++) history[i] = '0;
    fine_phase  = '0;
    drive_state = START_LEVEL_RST;
  endtask

  function automatic void apply_register(cfg_idx_t idx, cfg_data_t value);
    case (idx)
      REG_SETPOINT:    cfg_setpoint = setpoint_t'(value);
      REG_COARSE_BAND: cfg_coarse   = value[BAND_W-1:0];
      REG_FAST_BAND:   cfg_fast     = value[BAND_W-1:0];
      REG_FINE_BAND:   cfg_fine     = value[BAND_W-1:0];
      REG_FLOOR:       cfg_floor    = level_t'(value[LEVEL_W-1:0]);
      REG_CEILING:     cfg_ceiling  = level_t'(value[LEVEL_W-1:0]);
      REG_START_LEVEL: begin
        cfg_start   = level_t'(value[LEVEL_W-1:0]);
        drive_state = cfg_start;
      end
      default: ;
    endcase
  endfunction

  // +1 strictly above the band, -1 strictly below its negative
  function automatic int band_vote(longint err, band_t band);
    longint b;
    b = longint'(band);
    if (err > b) return 1;
    if (err < -b) return -1;
    return 0;
  endfunction

  function automatic result_t advance_controller(sample_t s);
    result_t r;
    longint  sum;
    longint  err;
    longint  lvl;
    int      step;
    sum = longint'(s);
    for (int i = 0; i < HIST_DEPTH; i++) sum += longint'(history[i]);
    err = sum / TAPS - longint'(cfg_setpoint);
    if (err > longint'(ERR_MAX)) err = longint'(ERR_MAX);
    if (err < longint'(ERR_MIN)) err = longint'(ERR_MIN);
    step = band_vote(err, cfg_coarse) + band_vote(err, cfg_fast);
    if (fine_phase == '0) step += band_vote(err, cfg_fine);
    lvl = longint'(drive_state) + step;
    // floor first, ceiling last: an inverted pair resolves to the ceiling
    if (lvl < longint'(cfg_floor)) lvl = longint'(cfg_floor);
    if (lvl > longint'(cfg_ceiling)) lvl = longint'(cfg_ceiling);
    drive_state = level_t'(lvl);
    for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
    fine_phase = fine_phase + 7'd1;
    r.drive_level  = level_t'(lvl);
    r.error_value  = err_t'(err);
    r.step_applied = step_t'(step);
    return r;
  endfunction

  function automatic void report_mismatch(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $error("%s: expected %0d, actual %0d", name, want, got);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(advance_controller(in_bus.sample));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.sample <= sample_queue.pop_front();
          in_bus.valid  <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor, with its own long hold-off counter
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $error("result transfer with no sample pending");
        end else begin
          want = expected_results.pop_front();
          if (out_bus.drive_level !== want.drive_level)
            report_mismatch("drive_level", want.drive_level, out_bus.drive_level);
          if (out_bus.error_value !== want.error_value)
            report_mismatch("error_value", want.error_value, out_bus.error_value);
          if (out_bus.step_applied !== want.step_applied)
            report_mismatch("step_applied", want.step_applied, out_bus.step_applied);
        end
      end
      if (rx_hold_seen != rx_hold_req) begin
        rx_hold_seen  <= rx_hold_req;
        rx_hold_count <= RX_HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else if (rx_hold_count != 0) begin
        rx_hold_count <= rx_hold_count - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(cfg_idx_t idx, cfg_data_t value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_register(idx, value);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic write_all(cfg_data_t sp, cfg_data_t coarse, cfg_data_t fast,
                           cfg_data_t fine, level_t lo, level_t hi, level_t start);
    write_register(REG_SETPOINT, sp);
    write_register(REG_COARSE_BAND, coarse);
    write_register(REG_FAST_BAND, fast);
    write_register(REG_FINE_BAND, fine);
    write_register(REG_FLOOR, {16'($urandom), lo});
    write_register(REG_CEILING, {16'($urandom), hi});
    write_register(REG_START_LEVEL, {16'($urandom), start});
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // mostly samples around the setpoint so every band is exercised,
  // the rest full-range noise
  function automatic sample_t pick_sample();
    longint span;
    longint v;
    if ($urandom_range(99) < 30) return sample_t'($urandom);
    span = longint'(cfg_fast) + 16;
    if (span > 4000000) span = 4000000;
    v = longint'(cfg_setpoint) + longint'($urandom_range(0, 32'(2 * span))) - span;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    if (v < SAMPLE_MIN) v = SAMPLE_MIN;
    return sample_t'(v);
  endfunction

  task automatic run_phase(int mode, bit with_hold);
    @(negedge clk);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
    for (int i = 0; i < RAND_PER_PHASE; i++) sample_queue.push_back(pick_sample());
    if (with_hold) rx_hold_req++;
    drain();
  endtask

  initial begin
    level_t lo;
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.sample  = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_SETPOINT;
    cfg_bus.data   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_req    = 0;
    rx_hold_seen   = 0;
    rx_hold_count  = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under reset settings: first sample takes the fine step,
    // full-scale swings hit the ceiling clamp, steady runs land on band edges
    sample_queue.push_back(sample_t'(0));
    repeat (4) sample_queue.push_back(sample_t'(SAMPLE_MAX));
    repeat (5) sample_queue.push_back(sample_t'(SAMPLE_MIN));
    repeat (5) sample_queue.push_back(sample_t'(75));
    repeat (5) sample_queue.push_back(sample_t'(76));
    repeat (5) sample_queue.push_back(sample_t'(226));
    run_phase(0, 1'b0);

    for (int p = 1; p < PHASES; p++) begin
      case (p)
        1: begin
          // setpoint at the top, zero bands, widest limits
          write_all(24'h7FFFFF, 24'h000000, 24'h800000, 24'h000000,
                    -8'sd128, 8'sd127, 8'sd127);
          write_register(REG_UNUSED, cfg_data_t'($urandom));
        end
        2: begin
          // setpoint at the bottom, full bands, floor above ceiling
          write_all(24'h800000, 24'hFFFFFF, 24'h7FFFFF, 24'hFFFFFF,
                    8'sd127, -8'sd128, -8'sd128);
        end
        default: begin
          lo = level_t'($urandom_range(0, 127) - 128);
          write_all($urandom_range(0, 1) ? cfg_data_t'($urandom)
                                         : cfg_data_t'($urandom_range(0, 400) - 200),
                    cfg_data_t'($urandom_range(20, 120)),
                    cfg_data_t'($urandom_range(121, 400)),
                    cfg_data_t'($urandom_range(0, 19)),
                    lo, level_t'(lo + $urandom_range(0, 127)),
                    level_t'($urandom));
        end
      endcase
      run_phase(p % 4, p == 4);
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/dslc_pkg.sv
hw/rtl/dslc_ifs.sv
hw/rtl/dslc_mean.sv
hw/rtl/dslc_law.sv
hw/rtl/deadband_step_level_controller.sv
tb/testbench.sv
